// ----- design/i2cmts_pkg.sv -----
// Package with shared types, codes and constants of the I2C master transaction sequencer.
`default_nettype none

package i2cmts_pkg;

   localparam int BUFFER_DEPTH = 32;
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
   localparam int LEN_W        = 6;
   localparam int CMP_W        = 10;
   localparam int POS_MAX      = 63;

   // Host command codes.
   localparam logic [2:0] CMD_LOAD_TX  = 3'd0;
   localparam logic [2:0] CMD_START_WR = 3'd1;
   localparam logic [2:0] CMD_START_RD = 3'd2;
   localparam logic [2:0] CMD_BUS_EVT  = 3'd3;
   localparam logic [2:0] CMD_READ_RX  = 3'd4;

   // Engine status nibbles.
   localparam logic [3:0] ST_START  = 4'hE;
   localparam logic [3:0] ST_TXBYTE = 4'hC;
   localparam logic [3:0] ST_RXBYTE = 4'h8;

   // Start and acknowledge control codes.
   localparam logic [1:0] CTL_KEEP  = 2'd0;
   localparam logic [1:0] START_SET = 2'd1;
   localparam logic [1:0] START_CLR = 2'd2;
   localparam logic [1:0] ACK_ACK   = 2'd1;
   localparam logic [1:0] ACK_NACK  = 2'd2;

   // Source of the data byte that is merged in after the store read.
   localparam logic [1:0] SRC_NONE = 2'd0;
   localparam logic [1:0] SRC_TX   = 2'd1;
   localparam logic [1:0] SRC_RX   = 2'd2;

   typedef struct packed {
      logic [2:0] command;
      logic [6:0] device_address;
      logic [5:0] byte_count;
      logic [4:0] buffer_index;
      logic [7:0] data_byte;
      logic [3:0] bus_state;
      logic       ack_received;
      logic       arbitration_lost;
   } req_type;

   typedef struct packed {
      logic       write_data_valid;
      logic [7:0] write_data;
      logic [1:0] start_control;
      logic       stop_request;
      logic [1:0] ack_control;
      logic       bus_reset;
      logic       busy_res;
      logic [7:0] error_count;
      logic [7:0] read_data;
      logic       command_refused;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [7:0]        wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      rsp_type    rsp;
      logic [1:0] src;
   } stage_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n);
      if (CMP_W'(n) > CMP_W'(BUFFER_DEPTH)) begin
         return LEN_W'(BUFFER_DEPTH);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- design/i2cmts_req_if.sv -----
// Request channel interface: valid, ready and one request payload.
`default_nettype none

interface i2cmts_req_if
   import i2cmts_pkg::*;
;
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/i2cmts_rsp_if.sv -----
// Result channel interface: valid, ready and one result payload.
`default_nettype none

interface i2cmts_rsp_if
   import i2cmts_pkg::*;
;
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/i2cmts_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module i2cmts_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- design/i2cmts_ctrl.sv -----
// Request decoder and sequencer state: positions, lengths, busy flag and error count.
`default_nettype none

module i2cmts_ctrl
   import i2cmts_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req,
   output mem_req_type  tx_mem,
   output mem_req_type  rx_mem,
   output stage_type    stage
);

   logic [LEN_W-1:0] tx_len_ff, tx_len_in;
   logic [LEN_W-1:0] tx_pos_ff, tx_pos_in;
   logic [LEN_W-1:0] rx_len_ff, rx_len_in;
   logic [LEN_W-1:0] rx_pos_ff, rx_pos_in;
   logic             dir_read_ff, dir_read_in;
   logic [6:0]       target_ff, target_in;
   logic             busy_ff, busy_in;
   logic [7:0]       err_ff, err_in;

   logic idx_ok;
   logic tx_pos_ok;
   logic rx_pos_ok;
   logic host_cmd;

   assign idx_ok    = CMP_W'(req.buffer_index) < CMP_W'(BUFFER_DEPTH);
   assign tx_pos_ok = CMP_W'(tx_pos_ff) < CMP_W'(BUFFER_DEPTH);
   assign rx_pos_ok = CMP_W'(rx_pos_ff) < CMP_W'(BUFFER_DEPTH);
   assign host_cmd  = (req.command == CMD_LOAD_TX) || (req.command == CMD_START_WR) ||
                      (req.command == CMD_START_RD) || (req.command == CMD_READ_RX);

   always_comb begin
      tx_len_in   = tx_len_ff;
      tx_pos_in   = tx_pos_ff;
      rx_len_in   = rx_len_ff;
      rx_pos_in   = rx_pos_ff;
      dir_read_in = dir_read_ff;
      target_in   = target_ff;
      busy_in     = busy_ff;
      err_in      = err_ff;

      stage     = '0;
      stage.src = SRC_NONE;

      tx_mem       = '0;
      tx_mem.waddr = ADDR_W'(CMP_W'(req.buffer_index));
      tx_mem.wdata = req.data_byte;
      tx_mem.raddr = ADDR_W'(CMP_W'(tx_pos_ff));

      rx_mem       = '0;
      rx_mem.waddr = ADDR_W'(CMP_W'(rx_pos_ff));
      rx_mem.wdata = req.data_byte;
      rx_mem.raddr = ADDR_W'(CMP_W'(req.buffer_index));

      if (host_cmd && busy_ff) begin
         stage.rsp.command_refused = 1'b1;
      end else begin
         case (req.command)
            CMD_LOAD_TX: begin
               tx_mem.we = idx_ok;
            end
            CMD_START_WR: begin
               target_in                = req.device_address;
               tx_len_in                = clamp_len(req.byte_count);
               tx_pos_in                = '0;
               dir_read_in              = 1'b0;
               busy_in                  = 1'b1;
               stage.rsp.start_control  = START_SET;
            end
            CMD_START_RD: begin
               target_in                = req.device_address;
               rx_len_in                = clamp_len(req.byte_count);
               rx_pos_in                = '0;
               dir_read_in              = 1'b1;
               busy_in                  = 1'b1;
               stage.rsp.start_control  = START_SET;
            end
            CMD_BUS_EVT: begin
               if (!req.arbitration_lost && req.bus_state == ST_START) begin
                  stage.rsp.write_data_valid = 1'b1;
                  stage.rsp.write_data       = {target_ff, dir_read_ff};
                  stage.rsp.start_control    = START_CLR;
               end else if (!req.arbitration_lost && req.bus_state == ST_TXBYTE) begin
                  if (!req.ack_received) begin
                     stage.rsp.stop_request  = 1'b1;
                     stage.rsp.start_control = START_SET;
                     busy_in                 = 1'b0;
                  end else if (!dir_read_ff) begin
                     if (tx_pos_ff >= tx_len_ff) begin
                        stage.rsp.stop_request = 1'b1;
                        busy_in                = 1'b0;
                     end else begin
                        // The byte itself is merged in later from the registered store read.
                        stage.rsp.write_data_valid = 1'b1;
                        stage.src                  = tx_pos_ok ? SRC_TX : SRC_NONE;
                        tx_pos_in                  = tx_pos_ff + LEN_W'(1);
                     end
                  end
               end else if (!req.arbitration_lost && req.bus_state == ST_RXBYTE) begin
                  rx_mem.we = rx_pos_ok;
                  if (rx_pos_ff < LEN_W'(POS_MAX)) begin
                     rx_pos_in = rx_pos_ff + LEN_W'(1);
                  end
                  if (rx_pos_in < rx_len_ff) begin
                     stage.rsp.ack_control = ACK_ACK;
                  end else begin
                     stage.rsp.ack_control  = ACK_NACK;
                     stage.rsp.stop_request = 1'b1;
                     busy_in                = 1'b0;
                  end
               end else begin
                  stage.rsp.bus_reset = 1'b1;
                  busy_in             = 1'b0;
                  err_in              = err_ff + 8'd1;
               end
            end
            CMD_READ_RX: begin
               stage.src = idx_ok ? SRC_RX : SRC_NONE;
            end
            default: begin
            end
         endcase
      end

      stage.rsp.busy_res    = busy_in;
      stage.rsp.error_count = err_in;

      if (!accept) begin
         tx_mem.we = 1'b0;
         rx_mem.we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_len_ff   <= '0;
         tx_pos_ff   <= '0;
         rx_len_ff   <= '0;
         rx_pos_ff   <= '0;
         dir_read_ff <= 1'b0;
         target_ff   <= '0;
         busy_ff     <= 1'b0;
         err_ff      <= '0;
      end else if (accept) begin
         tx_len_ff   <= tx_len_in;
         tx_pos_ff   <= tx_pos_in;
         rx_len_ff   <= rx_len_in;
         rx_pos_ff   <= rx_pos_in;
         dir_read_ff <= dir_read_in;
         target_ff   <= target_in;
         busy_ff     <= busy_in;
         err_ff      <= err_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/i2c_master_transaction_sequencer.sv -----
// Top level of the I2C master transaction sequencer: stores, pipeline and result register.
//
// The block sits between a host and a byte-level I2C engine. Every request on req_chan
// (load a transmit byte, start a write or read, report an engine event, read a received
// byte) yields exactly one result on rsp_chan, in request order. A result carries the
// controls for the engine (byte to send, start, stop, ack, engine reset) plus the busy
// flag, the wrapping error count and any byte read back for the host.
// Transmit and receive bytes live in two 32-entry synchronous RAMs. A request is decoded
// and the scalar state updated in the cycle it is accepted, while the RAM read starts;
// the read data is merged into the result register when the middle stage moves on.
// A result becomes valid in the result register once its request has left the middle
// stage; one request is taken every cycle while the result receiver does not stall.
// Writes and reads of the same store always come from different requests, so a read
// sees every earlier write without forwarding.
// Reset clears the lengths, positions, busy flag, error count and both pipeline valid
// bits, and holds req_chan.ready low; store contents stay undefined until written.
// When the result receiver stalls, the result register and the middle stage hold, and
// req_chan.ready drops once both are full.
`default_nettype none

module i2c_master_transaction_sequencer
   import i2cmts_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   i2cmts_req_if.sink   req_chan,
   i2cmts_rsp_if.source rsp_chan
);

   mem_req_type tx_mem;
   mem_req_type rx_mem;
   stage_type   stage;
   logic [7:0]  tx_q;
   logic [7:0]  rx_q;

   stage_type s1_ff;
   logic      s1_valid_ff, s1_valid_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic out_free;
   logic s1_free;
   logic accept;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_free        = !s1_valid_ff || out_free;
   assign req_chan.ready = s1_free && !reset;
   assign accept         = req_chan.valid && s1_free && !reset;

   i2cmts_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_chan.payload),
      .tx_mem (tx_mem),
      .rx_mem (rx_mem),
      .stage  (stage)
   );

   i2cmts_ram #(.DEPTH(BUFFER_DEPTH), .WIDTH(8)) u_tx_ram (
      .clock (clock),
      .we    (tx_mem.we),
      .waddr (tx_mem.waddr),
      .wdata (tx_mem.wdata),
      .re    (accept),
      .raddr (tx_mem.raddr),
      .rdata (tx_q)
   );

   i2cmts_ram #(.DEPTH(BUFFER_DEPTH), .WIDTH(8)) u_rx_ram (
      .clock (clock),
      .we    (rx_mem.we),
      .waddr (rx_mem.waddr),
      .wdata (rx_mem.wdata),
      .re    (accept),
      .raddr (rx_mem.raddr),
      .rdata (rx_q)
   );

   // The RAM outputs only change on accept, which also moves the middle stage on,
   // so they stay paired with the request held in s1_ff.
   always_comb begin
      rsp_in = s1_ff.rsp;
      case (s1_ff.src)
         SRC_TX:  rsp_in.write_data = tx_q;
         SRC_RX:  rsp_in.read_data  = rx_q;
         default: begin
         end
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_free) begin
         s1_valid_in = accept;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= stage;
      end
      if (out_free && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

`default_nettype wire
